>>> sv/ft3_pkg.sv
// Shared types, widths and register indexes for the 3D frame transform.
// No dependencies; used by every module of the block.
package ft3_pkg;

  localparam int ENTRY_W = 18;
  localparam int COORD_W = 32;
  localparam int ROW_W = 3 * ENTRY_W;
  localparam int VEC_W = COORD_W + 1;
  localparam int PROD_W = ENTRY_W + VEC_W;
  localparam int SUM_W = PROD_W + 3;
  localparam int MATRIX_FRAC_MIN = 12;
  localparam int MATRIX_FRAC_DEF = 16;
  localparam int MID_W = SUM_W - MATRIX_FRAC_MIN;
  localparam int MID_SUM_W = MID_W + 1;
  localparam int Q_W = ENTRY_W + MID_W;
  localparam int SUM2_W = Q_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = ROW_W;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_ZERO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_ONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_TWO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd5;

  typedef enum logic [1:0] {
    CMD_TO_LOCAL = 2'd0,
    CMD_TO_WORLD = 2'd1,
    CMD_PROJECT = 2'd2,
    CMD_PASS = 2'd3
  } cmd_t;

  typedef logic [2:0][ENTRY_W-1:0] row_t;
  typedef row_t [2:0] matrix_t;
  typedef logic [2:0][COORD_W-1:0] vec_t;

  typedef struct packed {
    cmd_t cmd;
    logic [2:0][MID_W-1:0] val;
  } mid_t;

endpackage

>>> sv/ft3_matvec.sv
// First matrix-vector pass: operand select, nine products, row sums with rounding.
// Three register stages. Depends on ft3_pkg.
module ft3_matvec #(
  parameter int MATRIX_FRAC_BITS = ft3_pkg::MATRIX_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ft3_pkg::cmd_t     cmd,
  input  ft3_pkg::vec_t     point,
  input  ft3_pkg::matrix_t  matrix,
  input  ft3_pkg::vec_t     origin,
  output logic              out_valid,
  input  logic              out_stall,
  output ft3_pkg::mid_t     mid
);

  localparam logic signed [ft3_pkg::SUM_W-1:0] RND_HALF =
    {{(ft3_pkg::SUM_W-1){1'b0}}, 1'b1} << (MATRIX_FRAC_BITS - 1);

  logic                              a_valid;
  ft3_pkg::cmd_t                     a_cmd;
  logic signed [ft3_pkg::VEC_W-1:0]  a_vec [3];

  logic                              b_valid;
  ft3_pkg::cmd_t                     b_cmd;
  logic signed [ft3_pkg::VEC_W-1:0]  b_vec [3];
  logic signed [ft3_pkg::PROD_W-1:0] b_prod [3][3];

  logic                              ready_a;
  logic                              ready_b;
  logic                              ready_c;

  logic signed [ft3_pkg::VEC_W-1:0]  vec_next [3];
  logic signed [ft3_pkg::PROD_W-1:0] prod_next [3][3];
  logic signed [ft3_pkg::SUM_W-1:0]  sum [3];
  logic signed [ft3_pkg::SUM_W-1:0]  rnd [3];
  ft3_pkg::mid_t                     mid_next;

  assign ready_c = !out_valid || !out_stall;
  assign ready_b = !b_valid || ready_c;
  assign ready_a = !a_valid || ready_b;
  assign in_stall = !ready_a;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (cmd == ft3_pkg::CMD_TO_LOCAL) begin
        vec_next[j] = ft3_pkg::VEC_W'($signed(point[j])) -
                      ft3_pkg::VEC_W'($signed(origin[j]));
      end else begin
        vec_next[j] = ft3_pkg::VEC_W'($signed(point[j]));
      end
    end
  end

  always_comb begin
    logic signed [ft3_pkg::ENTRY_W-1:0] coef;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (a_cmd == ft3_pkg::CMD_TO_WORLD) begin
          coef = $signed(matrix[j][i]);
        end else begin
          coef = $signed(matrix[i][j]);
        end
        prod_next[i][j] = ft3_pkg::PROD_W'(coef) * ft3_pkg::PROD_W'(a_vec[j]);
      end
    end
  end

  always_comb begin
    mid_next.cmd = b_cmd;
    for (int i = 0; i < 3; i++) begin
      sum[i] = ft3_pkg::SUM_W'(b_prod[i][0]) + ft3_pkg::SUM_W'(b_prod[i][1]) +
               ft3_pkg::SUM_W'(b_prod[i][2]);
      rnd[i] = (sum[i] + RND_HALF) >>> MATRIX_FRAC_BITS;
      if (b_cmd == ft3_pkg::CMD_PASS) begin
        mid_next.val[i] = ft3_pkg::MID_W'(b_vec[i]);
      end else begin
        mid_next.val[i] = rnd[i][ft3_pkg::MID_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid <= in_valid;
      end
      if (ready_b) begin
        b_valid <= a_valid;
      end
      if (ready_c) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      a_cmd <= cmd;
      a_vec <= vec_next;
    end
    if (ready_b && a_valid) begin
      b_cmd <= a_cmd;
      b_vec <= a_vec;
      b_prod <= prod_next;
    end
    if (ready_c && b_valid) begin
      mid <= mid_next;
    end
  end

endmodule

>>> sv/ft3_finish.sv
// Second pass: projection products or origin add, final rounding and clamp.
// Two register stages ending in the output register. Depends on ft3_pkg.
module ft3_finish #(
  parameter int MATRIX_FRAC_BITS = ft3_pkg::MATRIX_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ft3_pkg::mid_t     mid,
  input  ft3_pkg::matrix_t  matrix,
  input  ft3_pkg::vec_t     origin,
  output logic              out_valid,
  input  logic              out_stall,
  output ft3_pkg::vec_t     result,
  output logic              saturated
);

  localparam logic signed [ft3_pkg::SUM2_W-1:0] RND_HALF =
    {{(ft3_pkg::SUM2_W-1){1'b0}}, 1'b1} << (MATRIX_FRAC_BITS - 1);
  localparam int HI_W = ft3_pkg::SUM2_W - ft3_pkg::COORD_W + 1;

  logic                               d_valid;
  ft3_pkg::cmd_t                      d_cmd;
  logic signed [ft3_pkg::Q_W-1:0]     d_q0 [3];
  logic signed [ft3_pkg::Q_W-1:0]     d_q1 [3];

  logic                               ready_d;
  logic                               ready_e;

  logic signed [ft3_pkg::Q_W-1:0]     q0_next [3];
  logic signed [ft3_pkg::Q_W-1:0]     q1_next [3];
  logic signed [ft3_pkg::SUM2_W-1:0]  sum2 [3];
  logic signed [ft3_pkg::SUM2_W-1:0]  rnd [3];
  logic signed [ft3_pkg::SUM2_W-1:0]  full [3];
  ft3_pkg::vec_t                      result_next;
  logic                               saturated_next;

  assign ready_e = !out_valid || !out_stall;
  assign ready_d = !d_valid || ready_e;
  assign in_stall = !ready_d;

  always_comb begin
    logic signed [ft3_pkg::MID_W-1:0]     t0;
    logic signed [ft3_pkg::MID_W-1:0]     t1;
    logic signed [ft3_pkg::MID_SUM_W-1:0] shifted;
    t0 = $signed(mid.val[0]);
    t1 = $signed(mid.val[1]);
    for (int i = 0; i < 3; i++) begin
      if (mid.cmd == ft3_pkg::CMD_TO_WORLD) begin
        shifted = ft3_pkg::MID_SUM_W'($signed(mid.val[i])) +
                  ft3_pkg::MID_SUM_W'($signed(origin[i]));
      end else begin
        shifted = ft3_pkg::MID_SUM_W'($signed(mid.val[i]));
      end
      if (mid.cmd == ft3_pkg::CMD_PROJECT) begin
        q0_next[i] = ft3_pkg::Q_W'($signed(matrix[0][i])) * ft3_pkg::Q_W'(t0);
        q1_next[i] = ft3_pkg::Q_W'($signed(matrix[1][i])) * ft3_pkg::Q_W'(t1);
      end else begin
        q0_next[i] = ft3_pkg::Q_W'(shifted);
        q1_next[i] = '0;
      end
    end
  end

  always_comb begin
    logic [HI_W-1:0] hi;
    logic            over;
    saturated_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum2[i] = ft3_pkg::SUM2_W'(d_q0[i]) + ft3_pkg::SUM2_W'(d_q1[i]);
      rnd[i] = (sum2[i] + RND_HALF) >>> MATRIX_FRAC_BITS;
      if (d_cmd == ft3_pkg::CMD_PROJECT) begin
        full[i] = rnd[i];
      end else begin
        full[i] = ft3_pkg::SUM2_W'(d_q0[i]);
      end
      hi = full[i][ft3_pkg::SUM2_W-1:ft3_pkg::COORD_W-1];
      over = !((&hi) || !(|hi));
      if (over) begin
        result_next[i] = full[i][ft3_pkg::SUM2_W-1] ?
                         {1'b1, {(ft3_pkg::COORD_W-1){1'b0}}} :
                         {1'b0, {(ft3_pkg::COORD_W-1){1'b1}}};
      end else begin
        result_next[i] = full[i][ft3_pkg::COORD_W-1:0];
      end
      saturated_next = saturated_next | over;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_d) begin
        d_valid <= in_valid;
      end
      if (ready_e) begin
        out_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d && in_valid) begin
      d_cmd <= mid.cmd;
      d_q0 <= q0_next;
      d_q1 <= q1_next;
    end
    if (ready_e && d_valid) begin
      result <= result_next;
      saturated <= saturated_next;
    end
  end

endmodule

>>> sv/frame_transform_3d.sv
// Top level of the 3D rigid frame transform: frame registers and the two pipeline halves.
// Depends on ft3_pkg, ft3_matvec and ft3_finish.
//
// Usage:
//   Write the frame through the cfg channel (cfg_ready is always high): index 0..2 load
//   matrix rows (three signed 18-bit entries, column zero in the low bits), index 3..5
//   load the origin. Indexes 6 and 7 are ignored. Write only while no request is in flight.
//   Each request on the input channel (cmd, point_x/y/z) yields one result on the
//   output channel (result_x/y/z, saturated): cmd 0 world to local, 1 local to world,
//   2 projection onto the plane of matrix rows zero and one, 3 pass through.
//   Throughput: one request per cycle when the output is not stalled, set by the five register
//   stages (operand, products, row sums, second products, output) that each hold one request.
//   When out_stall is high the output register holds; earlier stages keep filling any
//   empty slots, and in_stall rises only once every stage holds a request.
//   Reset clears all frame registers to zero and empties the pipeline.
module frame_transform_3d #(
  parameter int MATRIX_FRAC_BITS = ft3_pkg::MATRIX_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ft3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ft3_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      cmd,
  input  logic signed [ft3_pkg::COORD_W-1:0] point_x,
  input  logic signed [ft3_pkg::COORD_W-1:0] point_y,
  input  logic signed [ft3_pkg::COORD_W-1:0] point_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [ft3_pkg::COORD_W-1:0] result_x,
  output logic signed [ft3_pkg::COORD_W-1:0] result_y,
  output logic signed [ft3_pkg::COORD_W-1:0] result_z,
  output logic                            saturated
);

  ft3_pkg::matrix_t matrix;
  ft3_pkg::vec_t    origin;
  ft3_pkg::vec_t    point;
  ft3_pkg::vec_t    result;
  ft3_pkg::mid_t    mid;
  logic             mid_valid;
  logic             mid_stall;

  assign cfg_ready = 1'b1;
  assign point = {point_z, point_y, point_x};
  assign result_x = $signed(result[0]);
  assign result_y = $signed(result[1]);
  assign result_z = $signed(result[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix <= '0;
      origin <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ft3_pkg::REG_MATRIX_ROW_ZERO: matrix[0] <= cfg_data;
        ft3_pkg::REG_MATRIX_ROW_ONE:  matrix[1] <= cfg_data;
        ft3_pkg::REG_MATRIX_ROW_TWO:  matrix[2] <= cfg_data;
        ft3_pkg::REG_ORIGIN_X:        origin[0] <= cfg_data[ft3_pkg::COORD_W-1:0];
        ft3_pkg::REG_ORIGIN_Y:        origin[1] <= cfg_data[ft3_pkg::COORD_W-1:0];
        ft3_pkg::REG_ORIGIN_Z:        origin[2] <= cfg_data[ft3_pkg::COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ft3_matvec #(
    .MATRIX_FRAC_BITS(MATRIX_FRAC_BITS)
  ) u_matvec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (ft3_pkg::cmd_t'(cmd)),
    .point     (point),
    .matrix    (matrix),
    .origin    (origin),
    .out_valid (mid_valid),
    .out_stall (mid_stall),
    .mid       (mid)
  );

  ft3_finish #(
    .MATRIX_FRAC_BITS(MATRIX_FRAC_BITS)
  ) u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_stall  (mid_stall),
    .mid       (mid),
    .matrix    (matrix),
    .origin    (origin),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .saturated (saturated)
  );

endmodule

>>> tb/sv/tb_frame_transform_3d.sv
// Self-checking testbench for frame_transform_3d: directed table, then random frames and points.
// Expected points: table values for typed probes, else a fixed-point predictor kept in this file.
// Depends on ft3_pkg and the frame_transform_3d RTL.
module tb_frame_transform_3d;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MATRIX_FRAC = ft3_pkg::MATRIX_FRAC_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES = 8;
  localparam int POINTS_PER_PHASE = 60;

  localparam logic [ft3_pkg::ENTRY_W-1:0] ONE = 18'h10000;
  localparam logic [ft3_pkg::ENTRY_W-1:0] NEG_ONE = 18'h30000;
  localparam logic [ft3_pkg::ENTRY_W-1:0] HALF = 18'h08000;
  localparam logic [ft3_pkg::ENTRY_W-1:0] ENTRY_MAX = 18'h1FFFF;
  localparam logic [ft3_pkg::ENTRY_W-1:0] ENTRY_MIN = 18'h20000;
  localparam logic [ft3_pkg::COORD_W-1:0] CMAX = 32'h7FFFFFFF;
  localparam logic [ft3_pkg::COORD_W-1:0] CMIN = 32'h80000000;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    FRAME_RESET,
    FRAME_IDENTITY,
    FRAME_HALF,
    FRAME_MAX,
    FRAME_MIN
  } frame_kind_t;

  typedef struct packed {
    ft3_pkg::vec_t coord;
    logic sat;
  } coord_result_t;

  typedef struct packed {
    frame_kind_t frame;
    ft3_pkg::cmd_t op;
    logic [ft3_pkg::COORD_W-1:0] x, y, z;
    logic typed;
    logic [ft3_pkg::COORD_W-1:0] rx, ry, rz;
    logic rsat;
  } probe_t;

  probe_t probes [23] = '{
    '{FRAME_RESET, ft3_pkg::CMD_TO_LOCAL, CMAX, CMIN, 32'h12345678, 1'b1,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_RESET, ft3_pkg::CMD_TO_WORLD, CMIN, CMAX, 32'hFFFFFFFF, 1'b1,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_RESET, ft3_pkg::CMD_PROJECT, CMAX, CMAX, CMAX, 1'b1,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_RESET, ft3_pkg::CMD_PASS, CMAX, CMIN, 32'hA5A55A5A, 1'b1,
      CMAX, CMIN, 32'hA5A55A5A, 1'b0},
    '{FRAME_IDENTITY, ft3_pkg::CMD_TO_LOCAL, CMAX, CMIN, 32'd1, 1'b1,
      CMAX, CMIN, 32'd1, 1'b0},
    '{FRAME_IDENTITY, ft3_pkg::CMD_TO_WORLD, CMIN, 32'hFFFFFFFF, CMAX, 1'b1,
      CMIN, 32'hFFFFFFFF, CMAX, 1'b0},
    '{FRAME_IDENTITY, ft3_pkg::CMD_PROJECT, 32'h00030000, 32'hFFFE0000, 32'h00070000, 1'b1,
      32'h00030000, 32'hFFFE0000, 32'd0, 1'b0},
    '{FRAME_IDENTITY, ft3_pkg::CMD_PASS, CMIN, CMIN, CMIN, 1'b1,
      CMIN, CMIN, CMIN, 1'b0},
    '{FRAME_HALF, ft3_pkg::CMD_TO_LOCAL, 32'd1, 32'hFFFFFFFF, 32'd3, 1'b1,
      32'd1, 32'd0, 32'd2, 1'b0},
    '{FRAME_HALF, ft3_pkg::CMD_TO_WORLD, 32'd1, 32'hFFFFFFFF, 32'd3, 1'b1,
      32'd1, 32'd0, 32'd2, 1'b0},
    '{FRAME_HALF, ft3_pkg::CMD_TO_LOCAL, 32'hFFFFFFFD, 32'd5, 32'hFFFFFFFB, 1'b0,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_HALF, ft3_pkg::CMD_PROJECT, 32'h00010001, 32'hFFFF0001, 32'd7, 1'b0,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_MAX, ft3_pkg::CMD_TO_LOCAL, CMAX, CMAX, CMAX, 1'b1,
      CMAX, CMAX, CMAX, 1'b1},
    '{FRAME_MAX, ft3_pkg::CMD_TO_LOCAL, CMIN, CMIN, CMIN, 1'b1,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_MAX, ft3_pkg::CMD_TO_WORLD, CMAX, CMAX, CMAX, 1'b0,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_MAX, ft3_pkg::CMD_TO_WORLD, CMIN, CMIN, CMIN, 1'b0,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_MAX, ft3_pkg::CMD_PROJECT, CMAX, CMIN, CMAX, 1'b0,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_MAX, ft3_pkg::CMD_PASS, 32'd1, 32'd2, 32'd3, 1'b1,
      32'd1, 32'd2, 32'd3, 1'b0},
    '{FRAME_MIN, ft3_pkg::CMD_TO_LOCAL, CMIN, CMIN, CMIN, 1'b1,
      CMAX, CMAX, CMAX, 1'b1},
    '{FRAME_MIN, ft3_pkg::CMD_TO_LOCAL, CMAX, CMAX, CMAX, 1'b1,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_MIN, ft3_pkg::CMD_TO_WORLD, CMIN, CMIN, CMIN, 1'b0,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_MIN, ft3_pkg::CMD_PROJECT, CMIN, CMAX, CMIN, 1'b0,
      32'd0, 32'd0, 32'd0, 1'b0},
    '{FRAME_MIN, ft3_pkg::CMD_TO_WORLD, 32'd0, 32'd0, 32'd0, 1'b1,
      CMAX, CMAX, CMAX, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ft3_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ft3_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic signed [ft3_pkg::COORD_W-1:0] point_x = '0;
  logic signed [ft3_pkg::COORD_W-1:0] point_y = '0;
  logic signed [ft3_pkg::COORD_W-1:0] point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ft3_pkg::COORD_W-1:0] result_x;
  logic signed [ft3_pkg::COORD_W-1:0] result_y;
  logic signed [ft3_pkg::COORD_W-1:0] result_z;
  logic saturated;

  ft3_pkg::matrix_t frame_rows = '0;
  ft3_pkg::vec_t frame_origin = '0;
  coord_result_t awaited_points [$];
  int mismatch_count = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  wire progress = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                  (cfg_valid && cfg_ready);

  frame_transform_3d #(.MATRIX_FRAC_BITS(MATRIX_FRAC)) DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_x(result_x), .result_y(result_y), .result_z(result_z), .saturated(saturated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint unscale(longint v);
    return (v + (longint'(1) <<< (MATRIX_FRAC - 1))) >>> MATRIX_FRAC;
  endfunction

  function automatic coord_result_t transform_point(ft3_pkg::cmd_t op, ft3_pkg::vec_t pt);
    longint m [3][3];
    longint p [3];
    longint o [3];
    longint r [3];
    longint t [2];
    longint acc;
    coord_result_t res;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) m[i][j] = longint'($signed(frame_rows[i][j]));
      p[i] = longint'($signed(pt[i]));
      o[i] = longint'($signed(frame_origin[i]));
    end
    case (op)
      ft3_pkg::CMD_TO_LOCAL: begin
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc += m[i][j] * (p[j] - o[j]);
          r[i] = unscale(acc);
        end
      end
      ft3_pkg::CMD_TO_WORLD: begin
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc += m[j][i] * p[j];
          r[i] = unscale(acc) + o[i];
        end
      end
      ft3_pkg::CMD_PROJECT: begin
        for (int i = 0; i < 2; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc += m[i][j] * p[j];
          t[i] = unscale(acc);
        end
        for (int i = 0; i < 3; i++) r[i] = unscale(m[0][i] * t[0] + m[1][i] * t[1]);
      end
      default: begin
        for (int i = 0; i < 3; i++) r[i] = p[i];
      end
    endcase
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (r[i] > COORD_MAX) begin
        res.coord[i] = CMAX;
        res.sat = 1'b1;
      end else if (r[i] < COORD_MIN) begin
        res.coord[i] = CMIN;
        res.sat = 1'b1;
      end else begin
        res.coord[i] = r[i][31:0];
      end
    end
    return res;
  endfunction

  function automatic int idle_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ft3_pkg::ENTRY_W-1:0] pick_entry(int style);
    case (style)
      0: return ft3_pkg::ENTRY_W'($urandom);
      1: return ft3_pkg::ENTRY_W'($urandom_range(0, 2 * 65536) - 65536);
      default: begin
        case ($urandom_range(0, 4))
          0: return ENTRY_MAX;
          1: return ENTRY_MIN;
          2: return ONE;
          3: return NEG_ONE;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [ft3_pkg::COORD_W-1:0] pick_coord(int style);
    int r = $urandom_range(0, 99);
    if (style == 2 && r < 50) r = 90;
    if (r < 45) return $urandom;
    if (r < 80) return ft3_pkg::COORD_W'($urandom_range(0, 2 ** 21) - 2 ** 20);
    case ($urandom_range(0, 4))
      0: return CMAX;
      1: return CMIN;
      2: return 32'hFFFFFFFF;
      3: return 32'd1;
      default: return '0;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic send_point(ft3_pkg::cmd_t op, ft3_pkg::vec_t pt, bit typed,
                            coord_result_t want);
    int gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    point_x <= pt[0];
    point_y <= pt[1];
    point_z <= pt[2];
    do @(posedge clk); while (in_stall);
    awaited_points.push_back(typed ? want : transform_point(op, pt));
  endtask

  task automatic load_frame(ft3_pkg::matrix_t rows, ft3_pkg::vec_t org);
    in_valid <= 1'b0;
    while (awaited_points.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: begin cfg_index <= ft3_pkg::REG_MATRIX_ROW_ZERO; cfg_data <= rows[0]; end
        1: begin cfg_index <= ft3_pkg::REG_MATRIX_ROW_ONE; cfg_data <= rows[1]; end
        2: begin cfg_index <= ft3_pkg::REG_MATRIX_ROW_TWO; cfg_data <= rows[2]; end
        3: begin cfg_index <= ft3_pkg::REG_ORIGIN_X; cfg_data <= {22'($urandom), org[0]}; end
        4: begin cfg_index <= ft3_pkg::REG_ORIGIN_Y; cfg_data <= {22'($urandom), org[1]}; end
        default: begin
          cfg_index <= ft3_pkg::REG_ORIGIN_Z;
          cfg_data <= {22'($urandom), org[2]};
        end
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    frame_rows = rows;
    frame_origin = org;
  endtask

  always @(posedge clk) begin
    coord_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (awaited_points.size() == 0) begin
          report_mismatch("unrequested result_x", longint'(result_x), 0);
        end else begin
          want = awaited_points.pop_front();
          if (result_x !== want.coord[0])
            report_mismatch("result_x", longint'(result_x), longint'($signed(want.coord[0])));
          if (result_y !== want.coord[1])
            report_mismatch("result_y", longint'(result_y), longint'($signed(want.coord[1])));
          if (result_z !== want.coord[2])
            report_mismatch("result_z", longint'(result_z), longint'($signed(want.coord[2])));
          if (saturated !== want.sat)
            report_mismatch("saturated", longint'(saturated), longint'(want.sat));
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = quiet ? 0 : idle_len();
      end
    end
  end

  initial begin
    int stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (progress) stuck = 0;
      else stuck++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    ft3_pkg::matrix_t rows;
    ft3_pkg::vec_t org;
    ft3_pkg::vec_t pt;
    coord_result_t want;
    frame_kind_t cur;
    int style;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    cur = FRAME_RESET;
    foreach (probes[i]) begin
      if (probes[i].frame != cur) begin
        cur = probes[i].frame;
        rows = '0;
        org = '0;
        case (cur)
          FRAME_IDENTITY: for (int d = 0; d < 3; d++) rows[d][d] = ONE;
          FRAME_HALF: for (int d = 0; d < 3; d++) rows[d][d] = HALF;
          FRAME_MAX: begin
            rows = {9{ENTRY_MAX}};
            org = {3{CMIN}};
          end
          default: begin
            rows = {9{ENTRY_MIN}};
            org = {3{CMAX}};
          end
        endcase
        load_frame(rows, org);
      end
      want.coord = {probes[i].rz, probes[i].ry, probes[i].rx};
      want.sat = probes[i].rsat;
      send_point(probes[i].op, {probes[i].z, probes[i].y, probes[i].x}, probes[i].typed, want);
    end

    want = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      style = ph % 3;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) rows[i][j] = pick_entry(style);
        org[i] = pick_coord(style);
      end
      load_frame(rows, org);
      quiet = (ph == 4);
      for (int k = 0; k < POINTS_PER_PHASE; k++) begin
        for (int i = 0; i < 3; i++) pt[i] = pick_coord($urandom_range(0, 2));
        case ($urandom_range(0, 9))
          0, 1, 2: send_point(ft3_pkg::CMD_TO_LOCAL, pt, 1'b0, want);
          3, 4, 5: send_point(ft3_pkg::CMD_TO_WORLD, pt, 1'b0, want);
          6, 7, 8: send_point(ft3_pkg::CMD_PROJECT, pt, 1'b0, want);
          default: send_point(ft3_pkg::CMD_PASS, pt, 1'b0, want);
        endcase
      end
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    while (awaited_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
